FILE: hw/rtl/lbbc_pkg.sv
// Shared types and constants of the block buffer cache tag table.
package lbbc_pkg;

  localparam logic [7:0]  COUNT_MAX = 8'hff;
  localparam logic [31:0] TICK_MAX  = 32'hffffffff;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WRITE,
    S_READ,
    S_MODIFY
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] device;
    logic [31:0] block_number;
    logic [4:0]  slot_in;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [4:0] slot_out;
    logic       hit;
    logic       need_fill;
    status_e    status;
  } rsp_t;

  // One slot of the tag table as stored in the RAM.
  typedef struct packed {
    logic [15:0] device;
    logic [31:0] block;
    logic [7:0]  count;
    logic [31:0] last_use;
    logic        filled;
  } entry_t;

endpackage

FILE: hw/rtl/lru_block_buffer_cache_unit.sv
// Top level of the block buffer cache tag table with LRU slot replacement.
//
//  channel   | ports                  | beat taken when
//  ----------+------------------------+------------------------------
//  request   | start, busy, req_i     | start high and busy low
//  result    | done_o, rsp_o          | every cycle with done_o high
//
// A get makes one RAM read per slot while a single compare unit looks for the
// first match and the oldest free slot, then passes through the decide state,
// the write state and the output register. Release, pin and unpin pass through
// read, modify and write, and the output register. After reset every slot reads
// as zero through per-slot valid bits; no clearing pass is needed. The result
// cannot be stalled; a new request may be taken in the same cycle as the result
// of the previous one.
module lru_block_buffer_cache_unit #(
  parameter int SLOTS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  lbbc_pkg::req_t req_i,
  output logic           done_o,
  output lbbc_pkg::rsp_t rsp_o
);
  import lbbc_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = $bits(entry_t);

  // Map a slot index to the 5-bit result field.
  function automatic logic [4:0] slot5(logic [IW-1:0] idx);
    logic [IW+4:0] w;
    w = (IW+5)'(idx);
    return w[4:0];
  endfunction

  // Map the 5-bit request field to a slot index.
  function automatic logic [IW-1:0] slot_idx(logic [4:0] s);
    logic [IW+4:0] w;
    w = (IW+5)'(s);
    return w[IW-1:0];
  endfunction

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   eidx_q;
  logic            evld_q;
  logic            rd_valid_q;
  logic [SLOTS-1:0] valid_q;
  logic            match_q, match_d;
  logic [IW-1:0]   match_idx_q, match_idx_d;
  entry_t          match_ent_q, match_ent_d;
  logic            any_q, any_d;
  logic [IW-1:0]   best_idx_q, best_idx_d;
  logic [31:0]     best_time_q, best_time_d;
  logic            done_q, done_d;
  rsp_t            rsp_q, rsp_d;

  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [EW-1:0]   ram_rdata;
  entry_t          ent;
  logic            in_range;

  lbbc_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Slots never written read as zero.
  assign ent      = rd_valid_q ? entry_t'(ram_rdata) : '0;
  assign in_range = ((IW+5)'(req_q.slot_in) < (IW+5)'(SLOTS));
  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign rsp_o    = rsp_q;

  // Sequence the scan and the single-slot update.
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    idx_d       = idx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    match_ent_d = match_ent_q;
    any_d       = any_q;
    best_idx_d  = best_idx_q;
    best_time_d = best_time_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = idx_q;

    // Compare the slot read in the previous cycle.
    if (evld_q) begin
      if (!match_q && ent.device == req_q.device && ent.block == req_q.block_number) begin
        match_d     = 1'b1;
        match_idx_d = eidx_q;
        match_ent_d = ent;
      end
      if (ent.count == '0 && (!any_q || ent.last_use < best_time_q)) begin
        any_d       = 1'b1;
        best_idx_d  = eidx_q;
        best_time_d = ent.last_use;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d       = req_i;
          idx_d       = '0;
          match_d     = 1'b0;
          any_d       = 1'b0;
          best_time_d = TICK_MAX;
          state_d     = (req_i.cmd == CMD_GET) ? S_SCAN : S_READ;
        end
      end
      S_SCAN: begin
        if (idx_q == IW'(SLOTS - 1)) begin
          state_d = S_DECIDE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_DECIDE: begin
        state_d = S_WRITE;
      end
      S_WRITE: begin
        done_d         = 1'b1;
        rsp_d.hit      = match_q;
        rsp_d.status   = ST_OK;
        ram_wdata.device = req_q.device;
        ram_wdata.block  = req_q.block_number;
        ram_wdata.filled = 1'b1;
        if (match_q) begin
          ram_we             = 1'b1;
          ram_waddr          = match_idx_q;
          ram_wdata.last_use = match_ent_q.last_use;
          rsp_d.slot_out     = slot5(match_idx_q);
          rsp_d.need_fill    = !match_ent_q.filled;
          if (match_ent_q.count == COUNT_MAX) begin
            ram_wdata.count = COUNT_MAX;
            rsp_d.status    = ST_OVERFLOW;
          end else begin
            ram_wdata.count = match_ent_q.count + 8'd1;
          end
        end else if (any_q) begin
          ram_we             = 1'b1;
          ram_waddr          = best_idx_q;
          ram_wdata.count    = 8'd1;
          ram_wdata.last_use = best_time_q;
          rsp_d.slot_out     = slot5(best_idx_q);
          rsp_d.need_fill    = 1'b1;
        end else begin
          rsp_d.slot_out  = '0;
          rsp_d.need_fill = 1'b0;
          rsp_d.status    = ST_NO_FREE;
        end
        state_d = S_IDLE;
      end
      S_READ: begin
        ram_raddr = in_range ? slot_idx(req_q.slot_in) : '0;
        state_d   = S_MODIFY;
      end
      S_MODIFY: begin
        done_d          = 1'b1;
        rsp_d.slot_out  = req_q.slot_in;
        rsp_d.hit       = 1'b0;
        rsp_d.need_fill = 1'b0;
        rsp_d.status    = ST_OK;
        ram_waddr       = slot_idx(req_q.slot_in);
        ram_wdata       = ent;
        if (in_range) begin
          if (req_q.cmd == CMD_PIN) begin
            if (ent.count == COUNT_MAX) begin
              rsp_d.status = ST_OVERFLOW;
            end else begin
              ram_we          = 1'b1;
              ram_wdata.count = ent.count + 8'd1;
            end
          end else if (ent.count == '0) begin
            rsp_d.status = ST_UNDERFLOW;
          end else begin
            ram_we          = 1'b1;
            ram_wdata.count = ent.count - 8'd1;
            if (req_q.cmd == CMD_RELEASE && ent.count == 8'd1) begin
              ram_wdata.last_use = req_q.now;
            end
          end
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      evld_q  <= 1'b0;
      match_q <= 1'b0;
      any_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      evld_q  <= (state_q == S_SCAN);
      match_q <= match_d;
      any_q   <= any_d;
      done_q  <= done_d;
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  // Hold the request, the scan results and the result beat.
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    idx_q       <= idx_d;
    eidx_q      <= idx_q;
    rd_valid_q  <= valid_q[ram_raddr];
    match_idx_q <= match_idx_d;
    match_ent_q <= match_ent_d;
    best_idx_q  <= best_idx_d;
    best_time_q <= best_time_d;
    rsp_q       <= rsp_d;
  end

`ifndef SYNTH
  // A result beat only leaves an idle unit.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  // An accepted request occupies the unit.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // The scan index stays inside the table.
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ((IW+5)'(idx_q) < (IW+5)'(SLOTS)))
    else $error("scan index out of range");

  // A full table grants nothing.
  a_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status == ST_NO_FREE) |-> (!rsp_o.hit && !rsp_o.need_fill))
    else $error("grant reported with no free slot");
`endif

endmodule

FILE: hw/rtl/lbbc_ram.sv
// Generic RAM with one write port and one registered read port.
module lbbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and register the read word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
